[hw/rtl/bgd_pkg.sv]
`timescale 1ns / 1ps

package bgd_pkg;

  localparam int BUTTON_COUNT = 4;
  localparam int BTN_W        = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam int SHIFT_BIT    = 3;

  localparam int DEB_W  = 8;
  localparam int GAP_W  = 16;
  localparam int HOLD_W = 16;
  localparam int TAP_W  = 3;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [TAP_W-1:0] TAP_MAX = 3'd4;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 3'd0,
    CFG_GAP      = 3'd1,
    CFG_LONG     = 3'd2,
    CFG_VLONG    = 3'd3,
    CFG_VVLONG   = 3'd4,
    CFG_VVVLONG  = 3'd5,
    CFG_ACTIVE   = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    G_SINGLE  = 3'd0,
    G_DOUBLE  = 3'd1,
    G_TRIPLE  = 3'd2,
    G_LONG    = 3'd3,
    G_VLONG   = 3'd4,
    G_VVLONG  = 3'd5,
    G_LONGEST = 3'd6
  } gesture_t;

  // Gestures that ended in one tick, one slot per button.
  typedef struct packed {
    logic                          shift;
    logic     [BUTTON_COUNT-1:0]   hit;
    gesture_t [BUTTON_COUNT-1:0]   gest;
  } tick_rec_t;

endpackage

[hw/rtl/bgd_front.sv]
`timescale 1ns / 1ps

module bgd_front import bgd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 accept,
  input  logic [3:0]           raw_levels,
  output logic                 rec_push,
  output tick_rec_t            rec
);

  logic [DEB_W-1:0]  debounce_ticks;
  logic [GAP_W-1:0]  gap_ticks;
  logic [HOLD_W-1:0] long_limit;
  logic [HOLD_W-1:0] vlong_limit;
  logic [HOLD_W-1:0] vvlong_limit;
  logic [HOLD_W-1:0] vvvlong_limit;
  logic              active_level;

  logic [BUTTON_COUNT-1:0]              raw_prev, raw_prev_next;
  logic [BUTTON_COUNT-1:0]              stable_pressed, stable_pressed_next;
  logic [BUTTON_COUNT-1:0][DEB_W-1:0]   debounce_left, debounce_left_next;
  logic [BUTTON_COUNT-1:0]              debounce_running, debounce_running_next;
  logic [BUTTON_COUNT-1:0][GAP_W-1:0]   gap_left, gap_left_next;
  logic [BUTTON_COUNT-1:0]              gap_running, gap_running_next;
  logic [BUTTON_COUNT-1:0][TAP_W-1:0]   tap_count, tap_count_next;
  logic [BUTTON_COUNT-1:0][HOLD_W-1:0]  hold_ticks, hold_ticks_next;

  logic [DEB_W-1:0] deb_len;
  logic [GAP_W-1:0] gap_len;
  logic [BUTTON_COUNT-1:0] levels;

  function automatic gesture_t classify(input logic [TAP_W-1:0] taps,
                                        input logic [HOLD_W-1:0] h,
                                        input logic [HOLD_W-1:0] l0,
                                        input logic [HOLD_W-1:0] l1,
                                        input logic [HOLD_W-1:0] l2,
                                        input logic [HOLD_W-1:0] l3);
    gesture_t g;
    if (taps == 3'd2) begin
      g = G_DOUBLE;
    end else if (taps == 3'd3) begin
      g = G_TRIPLE;
    end else if (h < l0) begin
      g = G_SINGLE;
    end else if (h < l1) begin
      g = G_LONG;
    end else if (h < l2) begin
      g = G_VLONG;
    end else if (h < l3) begin
      g = G_VVLONG;
    end else begin
      g = G_LONGEST;
    end
    return g;
  endfunction

  assign deb_len = (debounce_ticks == '0) ? DEB_W'(1) : debounce_ticks;
  assign gap_len = (gap_ticks == '0) ? GAP_W'(1) : gap_ticks;

  always_comb begin
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      levels[b] = (b < 4) ? raw_levels[b % 4] : 1'b0;
    end
  end

  always_comb begin
    logic              lvl;
    logic              pressed;
    logic [HOLD_W-1:0] h;
    logic [GAP_W-1:0]  g;
    logic              gr;
    logic [TAP_W-1:0]  t;
    logic              s;
    logic [DEB_W-1:0]  d;
    logic              dr;
    rec       = '0;
    rec.shift = (raw_levels[SHIFT_BIT] == active_level);
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      lvl     = levels[b];
      pressed = (lvl == active_level);
      h  = hold_ticks[b];
      g  = gap_left[b];
      gr = gap_running[b];
      t  = tap_count[b];
      s  = stable_pressed[b];
      d  = debounce_left[b];
      dr = debounce_running[b];

      if (h != '1) begin
        h = h + HOLD_W'(1);
      end

      if (gr) begin
        if (g != '0) begin
          g = g - GAP_W'(1);
        end
        if (g == '0) begin
          if (s) begin
            g = gap_len;
          end else begin
            gr = 1'b0;
            if (t inside {[3'd1:3'd3]}) begin
              rec.hit[b]  = 1'b1;
              rec.gest[b] = classify(t, h, long_limit, vlong_limit, vvlong_limit,
                                     vvvlong_limit);
            end
            t = '0;
          end
        end
      end

      if (dr) begin
        if (d != '0) begin
          d = d - DEB_W'(1);
        end
        if (d == '0) begin
          dr = 1'b0;
          if (pressed != s) begin
            s  = pressed;
            g  = gap_len;
            gr = 1'b1;
            if (pressed) begin
              if (t < TAP_MAX) begin
                t = t + TAP_W'(1);
              end
              h = '0;
            end
          end
        end
      end

      if (lvl != raw_prev[b] && !dr) begin
        dr = 1'b1;
        d  = deb_len;
      end

      raw_prev_next[b]         = lvl;
      stable_pressed_next[b]   = s;
      debounce_left_next[b]    = d;
      debounce_running_next[b] = dr;
      gap_left_next[b]         = g;
      gap_running_next[b]      = gr;
      tap_count_next[b]        = t;
      hold_ticks_next[b]       = h;
    end
  end

  assign rec_push = accept && (rec.hit != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEB_W'(20);
      gap_ticks        <= GAP_W'(250);
      long_limit       <= HOLD_W'(1000);
      vlong_limit      <= HOLD_W'(2000);
      vvlong_limit     <= HOLD_W'(3000);
      vvvlong_limit    <= HOLD_W'(7000);
      active_level     <= 1'b1;
      raw_prev         <= '0;
      stable_pressed   <= '0;
      debounce_left    <= '0;
      debounce_running <= '0;
      gap_left         <= '0;
      gap_running      <= '0;
      tap_count        <= '0;
      hold_ticks       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_DEBOUNCE: debounce_ticks <= cfg_data[DEB_W-1:0];
          CFG_GAP:      gap_ticks      <= cfg_data[GAP_W-1:0];
          CFG_LONG:     long_limit     <= cfg_data[HOLD_W-1:0];
          CFG_VLONG:    vlong_limit    <= cfg_data[HOLD_W-1:0];
          CFG_VVLONG:   vvlong_limit   <= cfg_data[HOLD_W-1:0];
          CFG_VVVLONG:  vvvlong_limit  <= cfg_data[HOLD_W-1:0];
          CFG_ACTIVE:   active_level   <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        raw_prev         <= raw_prev_next;
        stable_pressed   <= stable_pressed_next;
        debounce_left    <= debounce_left_next;
        debounce_running <= debounce_running_next;
        gap_left         <= gap_left_next;
        gap_running      <= gap_running_next;
        tap_count        <= tap_count_next;
        hold_ticks       <= hold_ticks_next;
      end
    end
  end

  // A change of the debounced state always leaves the gap timer running.
  a_stable_starts_gap: assert property (@(posedge clk) disable iff (rst)
    ((stable_pressed ^ $past(stable_pressed)) & ~gap_running) == '0)
    else $error("debounced state changed without a running gap timer");

endmodule

[hw/rtl/bgd_fifo.sv]
`timescale 1ns / 1ps

module bgd_fifo import bgd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  tick_rec_t wdata,
  output logic      full,
  input  logic      pop,
  output tick_rec_t rdata,
  output logic      empty
);

  tick_rec_t                entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]    wr_ptr;
  logic [FIFO_PTR_W-1:0]    rd_ptr;
  logic [FIFO_CNT_W-1:0]    count;
  logic                     do_push;
  logic                     do_pop;

  assign full    = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + FIFO_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - FIFO_CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("queue count above depth");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    do_push |=> !empty)
    else $error("queue empty after a write");

endmodule

[hw/rtl/bgd_back.sv]
`timescale 1ns / 1ps

module bgd_back import bgd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  tick_rec_t        rdata,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output logic [1:0]       button,
  output logic             shift_held,
  output logic [2:0]       gesture,
  output logic             last
);

  logic [BUTTON_COUNT-1:0]            cur_hit;
  gesture_t [BUTTON_COUNT-1:0]        cur_gest;
  logic                               cur_shift;

  logic                               out_valid;
  logic [BTN_W-1:0]                   out_button;
  logic                               out_shift;
  gesture_t                           out_gesture;
  logic                               out_last;

  logic                               load_out;
  logic                               take;
  logic [BTN_W-1:0]                   sel;
  logic [BUTTON_COUNT-1:0]            rest;
  logic [BUTTON_COUNT-1:0]            remain;

  always_comb begin
    sel = '0;
    for (int b = BUTTON_COUNT - 1; b >= 0; b--) begin
      if (cur_hit[b]) begin
        sel = BTN_W'(b);
      end
    end
  end

  assign rest     = cur_hit & (cur_hit - BUTTON_COUNT'(1));
  assign load_out = !out_valid || pop;
  assign take     = load_out && (cur_hit != '0);
  assign remain   = take ? rest : cur_hit;
  assign q_pop    = (remain == '0) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_hit   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_hit <= rdata.hit;
      end else begin
        cur_hit <= remain;
      end
      if (load_out) begin
        out_valid <= take;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_gest  <= rdata.gest;
      cur_shift <= rdata.shift;
    end
    if (take) begin
      out_button  <= sel;
      out_shift   <= cur_shift;
      out_gesture <= cur_gest[sel];
      out_last    <= (rest == '0);
    end
  end

  assign empty      = !out_valid;
  assign button     = 2'(out_button);
  assign shift_held = out_shift;
  assign gesture    = out_gesture;
  assign last       = out_last;

  a_pending_shows: assert property (@(posedge clk) disable iff (rst)
    (cur_hit != '0 && !out_valid) |=> out_valid)
    else $error("pending gesture not moved to the output register");

endmodule

[hw/rtl/button_gesture_detector_top.sv]
`timescale 1ns / 1ps

// Channel   Handshake                  Data
// input     push / full                raw_levels
// result    empty / pop                button, shift_held, gesture, last
// config    cfg_we                     cfg_index, cfg_data
//
// A tick may be taken in every cycle while the queue has room.
// Each gesture is a separate transfer on the result side, so a tick with n gestures gives n transfers.
// The four-entry tick queue sets how far the input side may run ahead of the result side.
// Reset is synchronous and leaves the queue and the result register empty.
// A stall on pop fills the queue, and then full holds back the next tick.

module button_gesture_detector_top import bgd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 push,
  output logic                 full,
  input  logic [3:0]           raw_levels,
  output logic                 empty,
  input  logic                 pop,
  output logic [1:0]           button,
  output logic                 shift_held,
  output logic [2:0]           gesture,
  output logic                 last
);

  logic      accept;
  logic      rec_push;
  tick_rec_t rec;
  tick_rec_t q_rdata;
  logic      q_empty;
  logic      q_pop;

  assign accept = push && !full;

  bgd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .raw_levels (raw_levels),
    .rec_push   (rec_push),
    .rec        (rec)
  );

  bgd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (rec_push),
    .wdata (rec),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  bgd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .rdata      (q_rdata),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .button     (button),
    .shift_held (shift_held),
    .gesture    (gesture),
    .last       (last)
  );

endmodule

[verif/button_gesture_detector_top_tb.sv]
`timescale 1ns / 1ps

module button_gesture_detector_top_tb;
  import bgd_pkg::*;

  typedef struct packed {
    logic [1:0] btn;
    logic       shift;
    gesture_t   gest;
    logic       last;
  } gest_rec_t;

  typedef struct packed {
    logic [3:0] lv;
    int         ticks;
    logic       typed;
    logic [1:0] btn;
    logic       shift;
    gesture_t   gest;
  } stim_row_t;

  localparam int SEG_B = 3;
  localparam int SEG_C = 11;
  localparam int DIR_N = 26;

  localparam stim_row_t DIR_ROWS [DIR_N] = '{
    '{4'b0001,  30, 1'b0, 2'd0, 1'b0, G_SINGLE},
    '{4'b0000, 270, 1'b0, 2'd0, 1'b0, G_SINGLE},
    '{4'b0000,   1, 1'b1, 2'd0, 1'b0, G_SINGLE},
    '{4'b0001,   2, 1'b0, 2'd0, 1'b0, G_SINGLE},
    '{4'b0000,   2, 1'b0, 2'd0, 1'b0, G_SINGLE},
    '{4'b0000,   1, 1'b1, 2'd0, 1'b0, G_SINGLE},
    '{4'b0010,   9, 1'b0, 2'd0, 1'b0, G_SINGLE},
    '{4'b0000,   2, 1'b0, 2'd0, 1'b0, G_SINGLE},
    '{4'b1000,   1, 1'b1, 2'd1, 1'b1, G_LONGEST},
    '{4'b1111,   3, 1'b0, 2'd0, 1'b0, G_SINGLE},
    '{4'b0000,   4, 1'b0, 2'd0, 1'b0, G_SINGLE},
    '{4'b0001,   2, 1'b0, 2'd0, 1'b0, G_SINGLE},
    '{4'b0000,   2, 1'b0, 2'd0, 1'b0, G_SINGLE},
    '{4'b0001,   2, 1'b0, 2'd0, 1'b0, G_SINGLE},
    '{4'b0000,   4, 1'b0, 2'd0, 1'b0, G_SINGLE},
    '{4'b0000,   1, 1'b1, 2'd0, 1'b0, G_DOUBLE},
    '{4'b0110,   2, 1'b0, 2'd0, 1'b0, G_SINGLE},
    '{4'b0000,   2, 1'b0, 2'd0, 1'b0, G_SINGLE},
    '{4'b0110,   2, 1'b0, 2'd0, 1'b0, G_SINGLE},
    '{4'b0000,   2, 1'b0, 2'd0, 1'b0, G_SINGLE},
    '{4'b0110,   2, 1'b0, 2'd0, 1'b0, G_SINGLE},
    '{4'b0000,   2, 1'b0, 2'd0, 1'b0, G_SINGLE},
    '{4'b0100,   2, 1'b0, 2'd0, 1'b0, G_SINGLE},
    '{4'b0000,   2, 1'b0, 2'd0, 1'b0, G_SINGLE},
    '{4'b0100,   2, 1'b0, 2'd0, 1'b0, G_SINGLE},
    '{4'b0000,   8, 1'b0, 2'd0, 1'b0, G_SINGLE}
  };

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DEBOUNCE;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 push = 1'b0;
  logic                 full;
  logic [3:0]           raw_levels = 4'b0000;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [1:0]           button;
  logic                 shift_held;
  logic [2:0]           gesture;
  logic                 last;

  button_gesture_detector_top u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .raw_levels (raw_levels),
    .empty      (empty),
    .pop        (pop),
    .button     (button),
    .shift_held (shift_held),
    .gesture    (gesture),
    .last       (last)
  );

  logic [7:0]              deb_cfg;
  logic [15:0]             gap_cfg;
  logic [15:0]             long_lim;
  logic [15:0]             vlong_lim;
  logic [15:0]             vvlong_lim;
  logic [15:0]             vvvlong_lim;
  logic                    act_cfg;

  logic [BUTTON_COUNT-1:0] prev_raw;
  logic [BUTTON_COUNT-1:0] stable;
  logic [BUTTON_COUNT-1:0] deb_run;
  logic [BUTTON_COUNT-1:0] gap_run;
  logic [DEB_W-1:0]        deb_left [BUTTON_COUNT];
  logic [GAP_W-1:0]        gap_left [BUTTON_COUNT];
  logic [TAP_W-1:0]        taps     [BUTTON_COUNT];
  logic [HOLD_W-1:0]       hold     [BUTTON_COUNT];

  gest_rec_t tick_gestures [$];
  gest_rec_t gesture_q [$];

  int  errors = 0;
  int  predicted = 0;
  int  checked = 0;
  int  ticks_sent = 0;
  int  settings = 1;
  bit  no_gaps = 1'b0;
  bit  hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("** button_gesture_detector_top: FAILED **");
    $finish;
  end

  task automatic advance_buttons(input logic [3:0] lv);
    logic              shift;
    logic              lvl;
    logic              pressed;
    logic [GAP_W-1:0]  gap_len;
    logic [DEB_W-1:0]  deb_len;
    gest_rec_t         r;
    tick_gestures.delete();
    shift   = (lv[SHIFT_BIT] == act_cfg);
    gap_len = (gap_cfg == '0) ? 16'd1 : gap_cfg;
    deb_len = (deb_cfg == '0) ? 8'd1 : deb_cfg;
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      lvl     = lv[b];
      pressed = (lvl == act_cfg);
      if (hold[b] != 16'hFFFF) hold[b] = hold[b] + 1'b1;
      if (gap_run[b]) begin
        if (gap_left[b] != '0) gap_left[b] = gap_left[b] - 1'b1;
        if (gap_left[b] == '0) begin
          if (stable[b]) begin
            gap_left[b] = gap_len;
          end else begin
            gap_run[b] = 1'b0;
            if (taps[b] >= 3'd1 && taps[b] <= 3'd3 && tick_gestures.size() < 4) begin
              r.btn   = b[1:0];
              r.shift = shift;
              r.last  = 1'b0;
              if (taps[b] == 3'd2) r.gest = G_DOUBLE;
              else if (taps[b] == 3'd3) r.gest = G_TRIPLE;
              else if (hold[b] < long_lim) r.gest = G_SINGLE;
              else if (hold[b] < vlong_lim) r.gest = G_LONG;
              else if (hold[b] < vvlong_lim) r.gest = G_VLONG;
              else if (hold[b] < vvvlong_lim) r.gest = G_VVLONG;
              else r.gest = G_LONGEST;
              tick_gestures.push_back(r);
            end
            taps[b] = '0;
          end
        end
      end
      if (deb_run[b]) begin
        if (deb_left[b] != '0) deb_left[b] = deb_left[b] - 1'b1;
        if (deb_left[b] == '0) begin
          deb_run[b] = 1'b0;
          if (pressed != stable[b]) begin
            stable[b]   = pressed;
            gap_left[b] = gap_len;
            gap_run[b]  = 1'b1;
            if (pressed) begin
              if (taps[b] < TAP_MAX) taps[b] = taps[b] + 1'b1;
              hold[b] = '0;
            end
          end
        end
      end
      if (lvl != prev_raw[b] && !deb_run[b]) begin
        deb_run[b]  = 1'b1;
        deb_left[b] = deb_len;
      end
      prev_raw[b] = lvl;
    end
    if (tick_gestures.size() > 0) begin
      r = tick_gestures.pop_back();
      r.last = 1'b1;
      tick_gestures.push_back(r);
    end
  endtask

  task automatic send_tick(input logic [3:0] lv, input logic typed, input stim_row_t row);
    gest_rec_t r;
    while (!no_gaps && $urandom_range(99, 0) < 21) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    raw_levels <= lv;
    @(posedge clk);
    while (full) @(posedge clk);
    ticks_sent++;
    advance_buttons(lv);
    if (typed) begin
      r = '{btn: row.btn, shift: row.shift, gest: row.gest, last: 1'b1};
      gesture_q.push_back(r);
      predicted++;
    end else begin
      foreach (tick_gestures[j]) begin
        gesture_q.push_back(tick_gestures[j]);
        predicted++;
      end
    end
  endtask

  task automatic settle();
    push <= 1'b0;
    while (gesture_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_DEBOUNCE: deb_cfg     = val[7:0];
      CFG_GAP:      gap_cfg     = val;
      CFG_LONG:     long_lim    = val;
      CFG_VLONG:    vlong_lim   = val;
      CFG_VVLONG:   vvlong_lim  = val;
      CFG_VVVLONG:  vvvlong_lim = val;
      CFG_ACTIVE:   act_cfg     = val[0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [7:0] deb, input logic [15:0] gap,
                              input logic [15:0] l0, input logic [15:0] l1,
                              input logic [15:0] l2, input logic [15:0] l3,
                              input logic act);
    settle();
    put_reg(CFG_DEBOUNCE, {8'd0, deb});
    put_reg(CFG_GAP, gap);
    put_reg(CFG_LONG, l0);
    put_reg(CFG_VLONG, l1);
    put_reg(CFG_VVLONG, l2);
    put_reg(CFG_VVVLONG, l3);
    put_reg(CFG_ACTIVE, {15'd0, act});
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic run_random(input int n_items);
    logic [3:0]              lv;
    logic [BUTTON_COUNT-1:0] down;
    int                      left [BUTTON_COUNT];
    int                      done;
    int                      start_res;
    int                      deb_eff;
    int                      gap_eff;
    deb_eff   = (deb_cfg == '0) ? 1 : int'(deb_cfg);
    gap_eff   = (gap_cfg == '0) ? 1 : int'(gap_cfg);
    done      = 0;
    start_res = predicted;
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      down[b] = 1'b0;
      left[b] = $urandom_range(8, 1);
    end
    while ((done < n_items || predicted - start_res < 10) && done < 400) begin
      for (int b = 0; b < BUTTON_COUNT; b++) begin
        if (left[b] == 0) begin
          down[b] = ~down[b];
          if ($urandom_range(9, 0) == 0) left[b] = 1;
          else if (down[b]) left[b] = deb_eff + $urandom_range(24, 1);
          else if ($urandom_range(1, 0) == 1) left[b] = deb_eff + $urandom_range(gap_eff, 1);
          else left[b] = deb_eff + gap_eff + $urandom_range(8, 1);
        end
        left[b]--;
        lv[b] = down[b] ? act_cfg : ~act_cfg;
      end
      if ($urandom_range(99, 0) < 8) lv[$urandom_range(3, 0)] ^= 1'b1;
      send_tick(lv, 1'b0, '0);
      done++;
    end
  endtask

  initial begin : check_results
    int        hold_left;
    gest_rec_t want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (gesture_q.size() == 0) begin
          $error("unexpected gesture transfer: button %0d gesture %0d", button, gesture);
          errors++;
        end else begin
          want = gesture_q.pop_front();
          if (button !== want.btn) begin
            $error("button: expected %0d, got %0d", want.btn, button);
            errors++;
          end
          if (shift_held !== want.shift) begin
            $error("shift_held: expected %0d, got %0d", want.shift, shift_held);
            errors++;
          end
          if (gesture !== want.gest) begin
            $error("gesture: expected %0d, got %0d", want.gest, gesture);
            errors++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            errors++;
          end
        end
        checked++;
      end
      if (hold_req) begin
        hold_left = 300;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= no_gaps || ($urandom_range(99, 0) >= 21);
      end
    end
  end

  initial begin : stimulus
    deb_cfg     = 8'd20;
    gap_cfg     = 16'd250;
    long_lim    = 16'd1000;
    vlong_lim   = 16'd2000;
    vvlong_lim  = 16'd3000;
    vvvlong_lim = 16'd7000;
    act_cfg     = 1'b1;
    prev_raw    = {BUTTON_COUNT{~act_cfg}};
    stable      = '0;
    deb_run     = '0;
    gap_run     = '0;
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      deb_left[b] = '0;
      gap_left[b] = '0;
      taps[b]     = '0;
      hold[b]     = '0;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      if (i == SEG_B) program_regs(8'd0, 16'd0, 16'd4, 16'd6, 16'd8, 16'd10, 1'b1);
      if (i == SEG_C) program_regs(8'd1, 16'd3, 16'd4, 16'd6, 16'd8, 16'd10, 1'b1);
      for (int k = 0; k < DIR_ROWS[i].ticks; k++) begin
        send_tick(DIR_ROWS[i].lv, DIR_ROWS[i].typed && (k == DIR_ROWS[i].ticks - 1),
                  DIR_ROWS[i]);
      end
    end

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          program_regs(8'd1, 16'd4, 16'd4, 16'd8, 16'd12, 16'd16, 1'b1);
          hold_req = 1'b1;
        end
        1: program_regs(8'd2, 16'd3, $urandom_range(24, 0), $urandom_range(24, 0),
                        $urandom_range(24, 0), $urandom_range(24, 0), 1'b0);
        2: program_regs(8'd3, 16'd5, 16'd10, 16'd6, 16'd20, 16'd2, 1'b1);
        default: program_regs(8'd3, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
      endcase
      no_gaps = (p == 3);
      run_random(32);
    end
    no_gaps = 1'b0;

    push <= 1'b0;
    while (gesture_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d ticks and %0d gesture transfers over %0d register settings,",
             ticks_sent, checked, settings);
    $display("including tap counts, hold classes, inverted levels and a stalled receiver.");
    if (errors == 0) begin
      $display("** button_gesture_detector_top: PASSED **");
    end else begin
      $display("** button_gesture_detector_top: FAILED **");
    end
    $finish;
  end

endmodule
